### hdl/kal_pkg.sv
package kal_pkg;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_INSERT = 2'd3
	} kind_e;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_e;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned FOUND_W   = 4;
	localparam int unsigned COUNT_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	typedef struct packed {
		status_e              status;
		logic [FOUND_W-1:0]   found;
		logic [COUNT_W-1:0]   count;
		logic                 empty;
		logic                 full;
	} res_t;

endpackage

### hdl/keyed_array_list.sv
// Ordered list of keyed entries (32-bit key, 32-bit payload word) with append,
// search, remove and insert-at-position; every operation returns one result word
// with a status, the count after the operation and the empty and full flags.
// The entries sit in a memory with one read and one write port that reads or
// moves one entry a cycle under a small sequencer. A finished result waits in
// the sequencer while the output register is full and stalled. A new word is
// taken only while the sequencer is idle; a finished result waits in the output
// register and does not hold off the next word. Capacity is written through
// cfg_we / cfg_data; the user must write it only while idle, which the block
// does not enforce. 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES.
module keyed_array_list import kal_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            kind,
	input  logic [KEY_W-1:0]      key,
	input  logic [PAYLOAD_W-1:0]  payload,
	input  logic [POS_W-1:0]      position,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [FOUND_W-1:0]    found_position,
	output logic [COUNT_W-1:0]    entry_count_out,
	output logic                  is_empty,
	output logic                  is_full
);

	localparam int IW = $clog2(MAX_ENTRIES);

	logic [CAP_W-1:0] cap_q;
	logic             idle;
	logic             out_free;
	logic             res_valid;
	res_t             res;
	res_t             res_q;
	logic             out_valid_q;
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	logic [IW-1:0]    mem_raddr;
	entry_t           mem_wdata;
	entry_t           mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	kal_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.key      (key),
		.payload  (payload),
		.position (position),
		.cap      (cap_q),
		.idle     (idle),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	kal_store #(
		.DEPTH(MAX_ENTRIES)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_stall = !idle;
	assign out_free = !out_valid_q || !out_stall;

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = res_q.status;
	assign found_position  = res_q.found;
	assign entry_count_out = res_q.count;
	assign is_empty        = res_q.empty;
	assign is_full         = res_q.full;

endmodule

### hdl/kal_store.sv
module kal_store import kal_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hdl/kal_ctrl.sv
module kal_ctrl import kal_pkg::*; #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [1:0]                     kind,
	input  logic [KEY_W-1:0]               key,
	input  logic [PAYLOAD_W-1:0]           payload,
	input  logic [POS_W-1:0]               position,
	input  logic [CAP_W-1:0]               cap,
	output logic                           idle,
	input  logic                           out_free,
	output logic                           res_valid,
	output res_t                           res,
	output logic                           mem_we,
	output logic [$clog2(MAX_ENTRIES)-1:0] mem_waddr,
	output entry_t                         mem_wdata,
	output logic [$clog2(MAX_ENTRIES)-1:0] mem_raddr,
	input  entry_t                         mem_rdata
);

	localparam int IW   = $clog2(MAX_ENTRIES);
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_SHDN = 5'b00100,
		S_SHUP = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t             state_q, state_n;
	logic [CW-1:0]      cnt_q, cnt_n;
	logic [CW-1:0]      idx_q, idx_n;
	logic [IW-1:0]      found_q, found_n;
	status_e            status_q, status_n;
	logic [1:0]         kind_q;
	logic [IW-1:0]      pos_q;
	entry_t             item_q;

	logic [CMPW-1:0]    cap_x, max_x, eff_cap, cnt_x;
	logic               full;
	logic [CW-1:0]      idx_p1, idx_p2, idx_m1, idx_m2, cnt_m1;
	logic [CW:0]        idx_p1_wide;
	logic               accept;

	always_comb begin
		cap_x = CMPW'(cap);
		max_x = CMPW'(MAX_ENTRIES);
		cnt_x = CMPW'(cnt_q);
		if (cap == '0) begin
			eff_cap = CMPW'(1);
		end else if (cap_x > max_x) begin
			eff_cap = max_x;
		end else begin
			eff_cap = cap_x;
		end
		full = (cnt_x >= eff_cap);
	end

	assign idx_p1      = idx_q + 1'b1;
	assign idx_p2      = idx_q + 2'd2;
	assign idx_m1      = idx_q - 1'b1;
	assign idx_m2      = idx_q - 2'd2;
	assign cnt_m1      = cnt_q - 1'b1;
	assign idx_p1_wide = {1'b0, idx_q} + 1'b1;

	assign idle   = (state_q == S_IDLE);
	assign accept = idle && in_valid;

	always_comb begin
		state_n   = state_q;
		cnt_n     = cnt_q;
		idx_n     = idx_q;
		found_n   = found_q;
		status_n  = status_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[IW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = idx_p1[IW-1:0];
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				// prime the read port for the first step of the operation
				mem_raddr = (kind == KIND_INSERT) ? cnt_m1[IW-1:0] : '0;
				if (in_valid) begin
					status_n = ST_OK;
					found_n  = '0;
					idx_n    = '0;
					case (kind)
						KIND_APPEND: begin
							state_n = S_FIN;
							if (full) begin
								status_n = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_q[IW-1:0];
								mem_wdata = '{key: key, payload: payload};
								cnt_n     = cnt_q + 1'b1;
							end
						end
						KIND_SEARCH, KIND_REMOVE: begin
							state_n = S_SCAN;
						end
						KIND_INSERT: begin
							if (full) begin
								status_n = ST_FULL;
								state_n  = S_FIN;
							end else if (CMPW'(position) > cnt_x) begin
								status_n = ST_BADPOS;
								state_n  = S_FIN;
							end else begin
								idx_n   = cnt_q;
								state_n = S_SHUP;
							end
						end
						default: begin
							state_n = S_FIN;
						end
					endcase
				end
			end
			S_SCAN: begin
				// read data holds the entry at idx_q
				mem_raddr = idx_p1[IW-1:0];
				if (idx_q >= cnt_q) begin
					status_n = (cnt_q == '0) ? ST_EMPTY : ST_NOTFOUND;
					state_n  = S_FIN;
				end else if (mem_rdata.key == item_q.key) begin
					found_n = idx_q[IW-1:0];
					state_n = (kind_q == KIND_REMOVE) ? S_SHDN : S_FIN;
				end else begin
					idx_n = idx_p1;
				end
			end
			S_SHDN: begin
				// read data holds the entry at idx_q + 1
				mem_raddr = idx_p2[IW-1:0];
				if (idx_p1_wide < {1'b0, cnt_q}) begin
					mem_we = 1'b1;
					idx_n  = idx_p1;
				end else begin
					cnt_n   = cnt_m1;
					state_n = S_FIN;
				end
			end
			S_SHUP: begin
				// read data holds the entry at idx_q - 1
				mem_raddr = idx_m2[IW-1:0];
				if (CMPW'(idx_q) > CMPW'(pos_q)) begin
					mem_we = 1'b1;
					idx_n  = idx_m1;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = item_q;
					cnt_n     = cnt_q + 1'b1;
					state_n   = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_n   = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_comb begin
		res.status = status_q;
		res.found  = FOUND_W'(found_q);
		res.count  = COUNT_W'(cnt_q);
		res.empty  = (cnt_q == '0);
		res.full   = full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			found_q  <= '0;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_n;
			cnt_q    <= cnt_n;
			idx_q    <= idx_n;
			found_q  <= found_n;
			status_q <= status_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q         <= kind;
			pos_q          <= IW'(position);
			item_q.key     <= key;
			item_q.payload <= payload;
		end
	end

endmodule

### tb/tb_keyed_array_list.sv
`timescale 1ns / 1ps

module tb_keyed_array_list;
	import kal_pkg::*;

	localparam int DEPTH = 16;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_WORDS = 60;

	typedef struct {
		bit               is_cfg;
		logic [CAP_W-1:0] cap;
		kind_e            k;
		logic [KEY_W-1:0] ky;
		logic [PAYLOAD_W-1:0] pl;
		logic [POS_W-1:0] ps;
		bit               typed;
		res_t             want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CAP_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           kind = '0;
	logic [KEY_W-1:0]     key = '0;
	logic [PAYLOAD_W-1:0] payload = '0;
	logic [POS_W-1:0]     position = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           status;
	logic [FOUND_W-1:0]   found_position;
	logic [COUNT_W-1:0]   entry_count_out;
	logic                 is_empty;
	logic                 is_full;

	// mirror of the list contents and the capacity register
	logic [KEY_W-1:0]     list_keys [DEPTH];
	logic [PAYLOAD_W-1:0] list_pays [DEPTH];
	int                   list_n = 0;
	logic [CAP_W-1:0]     cap_reg = CAP_RESET;

	res_t                 pending_results [$];
	plan_row_t            plan_q [$];
	logic [KEY_W-1:0]     key_pool [8];
	int                   errors = 0;
	int                   burst_left = 0;
	int                   stall_left = 0;
	int                   stall_mode = 0;
	int                   stall_tick = 0;

	keyed_array_list #(.MAX_ENTRIES(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.key(key),
		.payload(payload),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_position(found_position),
		.entry_count_out(entry_count_out),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always #10 clk = ~clk;

	function automatic int eff_capacity();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return cap_reg;
	endfunction

	task automatic apply_list_op(input kind_e k, input logic [KEY_W-1:0] ky,
			input logic [PAYLOAD_W-1:0] pl, input logic [POS_W-1:0] ps, output res_t r);
		int hit;
		hit = -1;
		r.status = ST_OK;
		r.found = '0;
		case (k)
			KIND_APPEND: begin
				if (list_n >= eff_capacity()) begin
					r.status = ST_FULL;
				end else begin
					list_keys[list_n] = ky;
					list_pays[list_n] = pl;
					list_n++;
				end
			end
			KIND_SEARCH, KIND_REMOVE: begin
				for (int i = 0; i < list_n; i++)
					if (hit < 0 && list_keys[i] == ky)
						hit = i;
				if (hit >= 0) begin
					r.found = FOUND_W'(hit);
					if (k == KIND_REMOVE) begin
						for (int i = hit; i + 1 < list_n; i++) begin
							list_keys[i] = list_keys[i+1];
							list_pays[i] = list_pays[i+1];
						end
						list_n--;
					end
				end else begin
					r.status = (list_n == 0) ? ST_EMPTY : ST_NOTFOUND;
				end
			end
			default: begin
				// full is checked before the position
				if (list_n >= eff_capacity()) begin
					r.status = ST_FULL;
				end else if (ps > list_n) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = list_n; i > ps; i--) begin
						list_keys[i] = list_keys[i-1];
						list_pays[i] = list_pays[i-1];
					end
					list_keys[ps] = ky;
					list_pays[ps] = pl;
					list_n++;
				end
			end
		endcase
		r.count = COUNT_W'(list_n);
		r.empty = (list_n == 0);
		r.full = (list_n >= eff_capacity());
	endtask

	task automatic send_word(input kind_e k, input logic [KEY_W-1:0] ky,
			input logic [PAYLOAD_W-1:0] pl, input logic [POS_W-1:0] ps,
			input bit typed, input res_t want);
		res_t r;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		key <= ky;
		payload <= pl;
		position <= ps;
		do
			@(posedge clk);
		while (in_stall);
		apply_list_op(k, ky, pl, ps, r);
		pending_results.push_back(typed ? want : r);
	endtask

	task automatic sender_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	// hold the sender until every word has come back and the sequencer is quiet
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		settle_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	task automatic plan_op(input kind_e k, input logic [KEY_W-1:0] ky,
			input logic [PAYLOAD_W-1:0] pl, input logic [POS_W-1:0] ps);
		plan_row_t row;
		row = '{is_cfg: 1'b0, cap: '0, k: k, ky: ky, pl: pl, ps: ps, typed: 1'b0, want: '0};
		plan_q.push_back(row);
	endtask

	task automatic plan_typed(input kind_e k, input logic [KEY_W-1:0] ky,
			input logic [PAYLOAD_W-1:0] pl, input logic [POS_W-1:0] ps,
			input status_e st, input logic [FOUND_W-1:0] fp, input logic [COUNT_W-1:0] n,
			input logic em, input logic fu);
		plan_row_t row;
		row = '{is_cfg: 1'b0, cap: '0, k: k, ky: ky, pl: pl, ps: ps, typed: 1'b1,
			want: '{status: st, found: fp, count: n, empty: em, full: fu}};
		plan_q.push_back(row);
	endtask

	task automatic plan_cap(input logic [CAP_W-1:0] v);
		plan_row_t row;
		row = '{is_cfg: 1'b1, cap: v, k: KIND_APPEND, ky: '0, pl: '0, ps: '0, typed: 1'b0,
			want: '0};
		plan_q.push_back(row);
	endtask

	// mostly keys that are in the list or in a small pool so that hits and duplicates occur
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6 && list_n > 0)
			return list_keys[$urandom_range(0, list_n - 1)];
		if (r < 9)
			return key_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	// receiver stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(5, 40);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= (stall_tick % 3 == 0);
		endcase
		stall_tick <= stall_tick + 1;
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word with no pending expectation");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (found_position !== want.found) begin
					$error("found_position: expected %0d, got %0d", want.found, found_position);
					errors++;
				end
				if (entry_count_out !== want.count) begin
					$error("entry_count_out: expected %0d, got %0d", want.count, entry_count_out);
					errors++;
				end
				if (is_empty !== want.empty) begin
					$error("is_empty: expected %0d, got %0d", want.empty, is_empty);
					errors++;
				end
				if (is_full !== want.full) begin
					$error("is_full: expected %0d, got %0d", want.full, is_full);
					errors++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [CAP_W-1:0] phase_caps [8];
		kind_e k;
		logic [POS_W-1:0] ps;
		int r;

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = $urandom();
		phase_caps = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd10};
		phase_caps[7] = $urandom_range(0, 31);

		// directed words, starting from the reset capacity
		plan_typed(KIND_SEARCH, 32'h0, 32'h0, 5'd0, ST_EMPTY, 4'd0, 5'd0, 1'b1, 1'b0);
		plan_typed(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 5'd0, ST_EMPTY, 4'd0, 5'd0, 1'b1, 1'b0);
		plan_typed(KIND_INSERT, 32'h1, 32'h1, 5'd1, ST_BADPOS, 4'd0, 5'd0, 1'b1, 1'b0);
		plan_typed(KIND_INSERT, 32'h1, 32'h1, 5'd31, ST_BADPOS, 4'd0, 5'd0, 1'b1, 1'b0);
		plan_typed(KIND_APPEND, 32'h0, 32'hFFFF_FFFF, 5'd0, ST_OK, 4'd0, 5'd1, 1'b0, 1'b0);
		plan_op(KIND_INSERT, 32'hFFFF_FFFF, 32'h0, 5'd0);
		plan_op(KIND_APPEND, 32'h1234_5678, 32'hA5A5_A5A5, 5'd0);
		plan_op(KIND_SEARCH, 32'h0, 32'h0, 5'd0);
		plan_op(KIND_SEARCH, 32'hDEAD_BEEF, 32'h0, 5'd0);
		plan_op(KIND_INSERT, 32'h1, 32'h1, 5'd4);
		plan_op(KIND_INSERT, 32'h7, 32'h5A5A_5A5A, 5'd3);
		plan_op(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 5'd0);
		plan_op(KIND_REMOVE, 32'h7, 32'h0, 5'd0);
		// capacity of zero acts as one, already below the count
		plan_cap(5'd0);
		plan_typed(KIND_APPEND, 32'h9, 32'h9, 5'd0, ST_FULL, 4'd0, 5'd2, 1'b0, 1'b1);
		plan_typed(KIND_INSERT, 32'h9, 32'h9, 5'd31, ST_FULL, 4'd0, 5'd2, 1'b0, 1'b1);
		plan_op(KIND_SEARCH, 32'h1234_5678, 32'h0, 5'd0);
		plan_cap(5'd31);
		plan_op(KIND_REMOVE, 32'h0, 32'h0, 5'd0);
		plan_op(KIND_REMOVE, 32'h1234_5678, 32'h0, 5'd0);
		plan_typed(KIND_SEARCH, 32'h1234_5678, 32'h0, 5'd0, ST_EMPTY, 4'd0, 5'd0, 1'b1, 1'b0);
		plan_cap(5'd1);
		plan_typed(KIND_APPEND, 32'hFFFF_0000, 32'h0000_FFFF, 5'd0, ST_OK, 4'd0, 5'd1, 1'b0,
			1'b1);
		plan_typed(KIND_APPEND, 32'h5, 32'h5, 5'd0, ST_FULL, 4'd0, 5'd1, 1'b0, 1'b1);
		plan_op(KIND_REMOVE, 32'hFFFF_0000, 32'h0, 5'd0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan_q[i]) begin
			if (plan_q[i].is_cfg) begin
				write_capacity(plan_q[i].cap);
			end else begin
				send_word(plan_q[i].k, plan_q[i].ky, plan_q[i].pl, plan_q[i].ps,
					plan_q[i].typed, plan_q[i].want);
				sender_gap();
			end
		end

		// random phases: first half grows the list, second half drains it
		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				r = $urandom_range(0, 99);
				if (n < PHASE_WORDS / 2)
					k = (r < 40) ? KIND_APPEND : (r < 75) ? KIND_INSERT :
						(r < 88) ? KIND_SEARCH : KIND_REMOVE;
				else
					k = (r < 15) ? KIND_APPEND : (r < 30) ? KIND_INSERT :
						(r < 55) ? KIND_SEARCH : KIND_REMOVE;
				if ($urandom_range(0, 4) == 0)
					ps = $urandom_range(0, 31);
				else
					ps = $urandom_range(0, list_n);
				send_word(k, (k == KIND_APPEND || k == KIND_INSERT) &&
					$urandom_range(0, 2) == 0 ? $urandom() : pick_key(),
					$urandom(), ps, 1'b0, '0);
				sender_gap();
			end
		end

		settle_idle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
hdl/kal_pkg.sv
hdl/kal_store.sv
hdl/kal_ctrl.sv
hdl/keyed_array_list.sv
tb/tb_keyed_array_list.sv
